// File: design/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types, constants and helpers of the palette pixel expander.
// ----------------------------------------------------------------------------
`default_nettype none

package ppe_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  typedef logic [PAL_AW-1:0] pal_addr_t;

  typedef enum logic [1:0] {
    BPP1 = 2'd0,
    BPP2 = 2'd1,
    BPP4 = 2'd2,
    BPP8 = 2'd3
  } bpp_mode_e;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_EXPAND = 1'b1
  } action_e;

  // Palette write port
  typedef struct packed {
    logic        we;
    pal_addr_t   addr;
    logic [23:0] data;
  } pal_wr_t;

  // Palette read port
  typedef struct packed {
    logic      re;
    pal_addr_t addr;
  } pal_rd_t;

  // Pixel beat issued toward the output stage
  typedef struct packed {
    logic valid;
    logic last;
    logic oor;
  } px_issue_t;

  // Slot number of the final pixel of a byte
  function automatic logic [2:0] last_slot(bpp_mode_e mode);
    logic [2:0] s;
    unique case (mode)
      BPP1:    s = 3'd7;
      BPP2:    s = 3'd3;
      BPP4:    s = 3'd1;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // Palette index of slot k of a packed byte
  function automatic logic [7:0] pixel_index(logic [7:0] pkd, bpp_mode_e mode,
                                             logic [2:0] k);
    logic [7:0] idx;
    logic [2:0] sh;
    sh = 3'd6 - {k[1:0], 1'b0};
    unique case (mode)
      BPP1:    idx = {7'd0, pkd[k]};
      BPP2:    idx = {6'd0, pkd[sh +: 2]};
      BPP4:    idx = k[0] ? {4'd0, pkd[3:0]} : {4'd0, pkd[7:4]};
      default: idx = pkd;
    endcase
    return idx;
  endfunction

  function automatic logic index_in_range(logic [7:0] idx);
    return ({1'b0, idx} < 9'(PALETTE_ENTRIES));
  endfunction

  // Keep the top five bits of each channel; bit 5 stays zero
  function automatic logic [15:0] rgb888_to_rgb16(logic [23:0] e);
    return {e[23:19], e[15:11], 1'b0, e[7:3]};
  endfunction

endpackage

`default_nettype wire

// File: design/ppe_palette_ram.sv
// ----------------------------------------------------------------------------
// ppe_palette_ram
// Palette memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_palette_ram (
  input  wire logic            clk_i,
  input  wire ppe_pkg::pal_wr_t wr_i,
  input  wire ppe_pkg::pal_rd_t rd_i,
  output logic [23:0]           rd_data_o
);

  logic [23:0] mem_q [ppe_pkg::PALETTE_ENTRIES];
  logic [23:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: design/ppe_unpack.sv
// ----------------------------------------------------------------------------
// ppe_unpack
// Input register and pixel sequencer: holds one beat, writes the palette for
// load beats and walks the pixel slots of an expand beat, one per cycle while the output stage is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_unpack (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              action_i,
  input  wire logic [7:0]        entry_index_i,
  input  wire logic [7:0]        red_value_i,
  input  wire logic [7:0]        green_value_i,
  input  wire logic [7:0]        blue_value_i,
  input  wire logic [7:0]        packed_byte_i,
  input  wire logic              stage_ready_i,
  output ppe_pkg::px_issue_t     issue_o,
  output ppe_pkg::pal_wr_t       pal_wr_o,
  output ppe_pkg::pal_rd_t       pal_rd_o
);

  ppe_pkg::bpp_mode_e mode_q;

  logic        a_valid_q, a_valid_d;
  logic        a_load_q;
  logic [2:0]  a_k_q, a_k_d;
  logic [7:0]  a_byte_q;
  logic [7:0]  a_entry_q;
  logic [23:0] a_rgb_q;

  logic       accept;
  logic       issue;
  logic       last_pix;
  logic       done;
  logic [7:0] idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ppe_pkg::BPP8;
    end else if (cfg_we_i) begin
      mode_q <= ppe_pkg::bpp_mode_e'(cfg_wdata_i);
    end
  end

  always_comb begin
    idx      = ppe_pkg::pixel_index(a_byte_q, mode_q, a_k_q);
    last_pix = (a_k_q == ppe_pkg::last_slot(mode_q));
    issue    = a_valid_q && !a_load_q && stage_ready_i;
    // a load beat retires as soon as it is held; an expand beat on its last pixel
    done     = a_valid_q && (a_load_q || (stage_ready_i && last_pix));
    in_ready_o = !a_valid_q || done;
    accept   = in_valid_i && in_ready_o;

    a_valid_d = a_valid_q;
    a_k_d     = a_k_q;
    if (accept) begin
      a_valid_d = 1'b1;
      a_k_d     = 3'd0;
    end else if (done) begin
      a_valid_d = 1'b0;
    end else if (issue) begin
      a_k_d = a_k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_k_q     <= 3'd0;
    end else begin
      a_valid_q <= a_valid_d;
      a_k_q     <= a_k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_load_q  <= (action_i == ppe_pkg::ACT_LOAD);
      a_byte_q  <= packed_byte_i;
      a_entry_q <= entry_index_i;
      a_rgb_q   <= {red_value_i, green_value_i, blue_value_i};
    end
  end

  always_comb begin
    pal_wr_o.we   = a_valid_q && a_load_q && ppe_pkg::index_in_range(a_entry_q);
    pal_wr_o.addr = a_entry_q[ppe_pkg::PAL_AW-1:0];
    pal_wr_o.data = a_rgb_q;

    pal_rd_o.re   = issue;
    pal_rd_o.addr = idx[ppe_pkg::PAL_AW-1:0];

    issue_o.valid = issue;
    issue_o.last  = last_pix;
    issue_o.oor   = !ppe_pkg::index_in_range(idx);
  end

endmodule

`default_nettype wire

// File: design/ppe_color_out.sv
// ----------------------------------------------------------------------------
// ppe_color_out
// Output register: holds one pixel beat, formats the palette entry into the
// 16-bit color word and drives the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_color_out (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ppe_pkg::px_issue_t issue_i,
  input  wire logic [23:0]        rd_data_i,
  output logic                    stage_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [15:0]             pixel_color_o,
  output logic                    last_of_byte_o
);

  logic b_valid_q;
  logic b_last_q;
  logic b_oor_q;

  // advance when empty or when the held beat leaves this cycle
  assign stage_ready_o = !b_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (stage_ready_o) begin
      b_valid_q <= issue_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready_o && issue_i.valid) begin
      b_last_q <= issue_i.last;
      b_oor_q  <= issue_i.oor;
    end
  end

  assign out_valid_o    = b_valid_q;
  assign last_of_byte_o = b_last_q;
  assign pixel_color_o  = b_oor_q ? 16'd0 : ppe_pkg::rgb888_to_rgb16(rd_data_i);

endmodule

`default_nettype wire

// File: design/palette_pixel_expander_unit.sv
// ----------------------------------------------------------------------------
// palette_pixel_expander_unit
// Expands packed palette-indexed bytes into 16-bit colors through an RGB888
// palette that load beats fill.
// ----------------------------------------------------------------------------
// A load beat writes one palette entry and retires with no result. An expand
// beat yields 8, 4, 2 or 1 color beats at 1, 2, 4 or 8 bpp, one per cycle
// while the output stage is ready, and holds the input register until its
// last pixel is issued; the single palette read port sets this pace. Colors
// pass the input register, then the palette read and output registers; the
// next beat is taken in the cycle the last pixel of the current one is issued.
// The palette holds no reset value: read only entries that were written.
`default_nettype none

module palette_pixel_expander_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [7:0]  red_value_i,
  input  wire logic [7:0]  green_value_i,
  input  wire logic [7:0]  blue_value_i,
  input  wire logic [7:0]  packed_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      pixel_color_o,
  output logic             last_of_byte_o
);

  ppe_pkg::px_issue_t issue;
  ppe_pkg::pal_wr_t   pal_wr;
  ppe_pkg::pal_rd_t   pal_rd;
  logic [23:0]        rd_data;
  logic               stage_ready;

  ppe_unpack u_unpack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .entry_index_i (entry_index_i),
    .red_value_i   (red_value_i),
    .green_value_i (green_value_i),
    .blue_value_i  (blue_value_i),
    .packed_byte_i (packed_byte_i),
    .stage_ready_i (stage_ready),
    .issue_o       (issue),
    .pal_wr_o      (pal_wr),
    .pal_rd_o      (pal_rd)
  );

  ppe_palette_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (pal_wr),
    .rd_i      (pal_rd),
    .rd_data_o (rd_data)
  );

  ppe_color_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .issue_i        (issue),
    .rd_data_i      (rd_data),
    .stage_ready_o  (stage_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_color_o  (pixel_color_o),
    .last_of_byte_o (last_of_byte_o)
  );

endmodule

`default_nettype wire

// File: design/ppe_checker.sv
// ----------------------------------------------------------------------------
// ppe_checker
// Port-level checks on the palette pixel expander, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic [1:0]  cfg_wdata_i,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        action_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] pixel_color_o,
  input wire logic        last_of_byte_o
);

  ppe_pkg::bpp_mode_e mode_q;

  // shadow of the depth register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ppe_pkg::BPP8;
    end else if (cfg_we_i) begin
      mode_q <= ppe_pkg::bpp_mode_e'(cfg_wdata_i);
    end
  end

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_color_o)
      && $stable(last_of_byte_o))
    else $error("result beat changed while stalled");

  // the input side only backs up behind a pixel in flight
  a_busy_feeds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o)
    else $error("input stalled with no pixel pending");

  // at 8 bpp every pixel closes its byte
  a_bpp8_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q == ppe_pkg::BPP8 |-> last_of_byte_o)
    else $error("8 bpp pixel without last mark");

  // bit 5 of a color word is always zero
  a_bit5_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !pixel_color_o[5])
    else $error("color bit 5 set");

  // a load beat into an empty block produces nothing
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ppe_pkg::ACT_LOAD && !out_valid_o
      && $past(in_ready_o && !in_valid_i) && $past(!out_valid_o) |=> !out_valid_o)
    else $error("load beat produced a result");

endmodule

bind palette_pixel_expander_unit ppe_checker u_ppe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_we_i       (cfg_we_i),
  .cfg_wdata_i    (cfg_wdata_i),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .action_i       (action_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pixel_color_o  (pixel_color_o),
  .last_of_byte_o (last_of_byte_o)
);

`default_nettype wire
